@@ src/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// types, constants and helpers shared by the cookie timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int RES_LIMIT   = 8;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int NRES_W      = $clog2(RES_LIMIT + 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_CHECK = 2'd3;

  localparam logic KIND_TIMEOUT = 1'b0;
  localparam logic KIND_CHECK   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  timer_index;
    logic [15:0] timeout_ticks;
    logic [15:0] check_cookie;
  } ctb_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  fired_index;
    logic [15:0] fired_cookie;
    logic        cookie_current;
    logic [15:0] remaining_ticks;
    logic        timer_done;
    logic        last_result;
  } ctb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FLUSH
  } ctb_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DEC,
    OP_LOAD,
    OP_CLEAR
  } ctb_op_t;

  typedef struct packed {
    ctb_op_t          op;
    logic [IDX_W-1:0] addr;
    logic [15:0]      count;
    logic [15:0]      cookie;
  } ctb_cmd_t;

  function automatic ctb_out_t timeout_res(logic [7:0] idx, logic [15:0] cookie);
    ctb_out_t r;
    r                 = '0;
    r.result_kind     = KIND_TIMEOUT;
    r.fired_index     = idx;
    r.fired_cookie    = cookie;
    return r;
  endfunction

endpackage

@@ src/ctb_store.sv @@
// ----------------------------------------------------------------------------
// ctb_store
// timer count and cookie storage with the shared decrementer
// ----------------------------------------------------------------------------
module ctb_store (
  input  logic              clk,
  input  logic              rst_n,
  input  ctb_pkg::ctb_cmd_t cmd,
  output logic [15:0]       rd_count,
  output logic [15:0]       rd_cookie
);

  logic [15:0] count_r  [ctb_pkg::TIMER_COUNT];
  logic [15:0] cookie_r [ctb_pkg::TIMER_COUNT];
  logic [15:0] dec;

  assign rd_count  = count_r[cmd.addr];
  assign rd_cookie = cookie_r[cmd.addr];
  assign dec       = rd_count - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctb_pkg::TIMER_COUNT; i++) begin
        count_r[i]  <= '0;
        cookie_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        ctb_pkg::OP_DEC: begin
          if (rd_count != 16'd0) begin
            count_r[cmd.addr] <= dec;
          end
        end
        ctb_pkg::OP_LOAD: begin
          count_r[cmd.addr]  <= cmd.count;
          cookie_r[cmd.addr] <= cmd.cookie;
        end
        ctb_pkg::OP_CLEAR: begin
          count_r[cmd.addr] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/ctb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctb_ctrl
// request sequencer: tick sweep, start/stop/check, result staging
// ----------------------------------------------------------------------------
module ctb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ctb_pkg::ctb_in_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ctb_pkg::ctb_out_t  out_res,
  output ctb_pkg::ctb_cmd_t  cmd,
  input  logic [15:0]        rd_count,
  input  logic [15:0]        rd_cookie
);

  ctb_pkg::ctb_state_t            state_r, state_nxt;
  ctb_pkg::ctb_in_t               req_r, req_nxt;
  logic [ctb_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [15:0]                    gen_r, gen_nxt;
  logic [ctb_pkg::NRES_W-1:0]     nres_r, nres_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  ctb_pkg::ctb_out_t              pend_r, pend_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ctb_pkg::ctb_out_t              out_r, out_nxt;

  logic                           accept;
  logic                           out_free;
  logic                           idx_ok;
  logic                           sweep_last;
  logic                           capture;
  logic                           step;
  logic                           push;
  ctb_pkg::ctb_out_t              push_res;
  logic [15:0]                    gen_inc;
  logic [ctb_pkg::IDX_W-1:0]      req_addr;

  assign in_stall   = (state_r != ctb_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_res    = out_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign idx_ok     = req_r.timer_index < 8'(ctb_pkg::TIMER_COUNT);
  assign req_addr   = req_r.timer_index[ctb_pkg::IDX_W-1:0];
  assign sweep_last = (idx_r == ctb_pkg::IDX_W'(ctb_pkg::TIMER_COUNT - 1));
  assign capture    = (rd_count == 16'd1) && (nres_r < ctb_pkg::NRES_W'(ctb_pkg::RES_LIMIT));
  assign step       = !(capture && pend_valid_r && !out_free);
  assign gen_inc    = gen_r + 16'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ctb_pkg::ST_EXEC;
        end
      end
      ctb_pkg::ST_EXEC: begin
        state_nxt = (req_r.req_type == ctb_pkg::REQ_TICK) ? ctb_pkg::ST_SWEEP
                                                          : ctb_pkg::ST_FLUSH;
      end
      ctb_pkg::ST_SWEEP: begin
        if (step && sweep_last) begin
          state_nxt = ctb_pkg::ST_FLUSH;
        end
      end
      ctb_pkg::ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = ctb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    gen_nxt        = gen_r;
    nres_nxt       = nres_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = 1'b0;
    push_res       = pend_r;
    cmd            = '0;
    cmd.op         = ctb_pkg::OP_NONE;
    cmd.addr       = req_addr;

    unique case (state_r)
      ctb_pkg::ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req;
        end
      end
      ctb_pkg::ST_EXEC: begin
        idx_nxt  = '0;
        nres_nxt = '0;
        unique case (req_r.req_type)
          ctb_pkg::REQ_START: begin
            if (idx_ok) begin
              gen_nxt    = gen_inc;
              cmd.op     = ctb_pkg::OP_LOAD;
              cmd.count  = req_r.timeout_ticks;
              cmd.cookie = gen_inc;
              if (req_r.timeout_ticks == 16'd0) begin
                pend_valid_nxt = 1'b1;
                pend_nxt       = ctb_pkg::timeout_res(req_r.timer_index, gen_inc);
              end
            end
          end
          ctb_pkg::REQ_STOP: begin
            if (idx_ok) begin
              cmd.op = ctb_pkg::OP_CLEAR;
            end
          end
          ctb_pkg::REQ_CHECK: begin
            pend_valid_nxt           = 1'b1;
            pend_nxt                 = '0;
            pend_nxt.result_kind     = ctb_pkg::KIND_CHECK;
            pend_nxt.fired_index     = req_r.timer_index;
            if (idx_ok) begin
              pend_nxt.fired_cookie    = rd_cookie;
              pend_nxt.cookie_current  = (rd_cookie == req_r.check_cookie);
              pend_nxt.remaining_ticks = rd_count;
              pend_nxt.timer_done      = (rd_count == 16'd0);
            end else begin
              pend_nxt.timer_done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ctb_pkg::ST_SWEEP: begin
        cmd.addr = idx_r;
        if (step) begin
          cmd.op  = ctb_pkg::OP_DEC;
          idx_nxt = idx_r + 1'b1;
          if (capture) begin
            nres_nxt       = nres_r + 1'b1;
            pend_valid_nxt = 1'b1;
            pend_nxt       = ctb_pkg::timeout_res(8'(idx_r), rd_cookie);
            if (pend_valid_r) begin
              push     = 1'b1;
              push_res = pend_r;
            end
          end
        end
      end
      ctb_pkg::ST_FLUSH: begin
        if (pend_valid_r && out_free) begin
          push                 = 1'b1;
          push_res             = pend_r;
          push_res.last_result = 1'b1;
          pend_valid_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_res;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_nxt       = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctb_pkg::ST_IDLE;
      gen_r        <= '0;
      nres_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gen_r        <= gen_nxt;
      nres_r       <= nres_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  a_nres_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= ctb_pkg::NRES_W'(ctb_pkg::RES_LIMIT))
    else $error("timeout count past limit");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctb_pkg::ST_IDLE) |-> !pend_valid_r)
    else $error("staged result left behind at idle");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ctb_pkg::ST_EXEC))
    else $error("accepted request not executed");

endmodule

@@ src/cookie_timer_bank.sv @@
// ----------------------------------------------------------------------------
// cookie_timer_bank
// bank of countdown timers tagged with generation cookies
// ----------------------------------------------------------------------------
// start, stop and check pass through the exec and flush states, then ready again
// a tick sweeps every timer through the shared decrementer, one timer
//   a cycle; stalls on the result side stretch the sweep and the final flush
// one request at a time; results are staged in a pending register first
// reset clears all counts, cookies and the cookie generator
module cookie_timer_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ctb_pkg::ctb_in_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output ctb_pkg::ctb_out_t out_res
);

  ctb_pkg::ctb_cmd_t cmd;
  logic [15:0]       rd_count;
  logic [15:0]       rd_cookie;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cmd       (cmd),
    .rd_count  (rd_count),
    .rd_cookie (rd_cookie)
  );

  ctb_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_count  (rd_count),
    .rd_cookie (rd_cookie)
  );

endmodule
